// ===== src/nalsplit_pkg.sv =====
// ----------------------------------------------------------------------------
// NAL splitter package
// Types, field widths and header codes shared by the Annex B NAL splitter.
// ----------------------------------------------------------------------------
package nalsplit_pkg;

   // Packet and table limits.
   localparam int unsigned MAX_PACKET_BYTES = 1048576;
   localparam int unsigned MAX_NALS         = 64;

   // Field widths.
   localparam int unsigned OFFSET_W = 20;
   localparam int unsigned LENGTH_W = 21;
   localparam int unsigned POS_W    = 21;   // byte counter, holds MAX_PACKET_BYTES itself
   localparam int unsigned COUNT_W  = 7;    // record counter, holds MAX_NALS itself
   localparam int unsigned TYPE_W   = 6;
   localparam int unsigned INDEX_W  = 6;

   // Annex B three-byte start code as seen in the byte history.
   localparam logic [23:0] START_CODE = 24'h000001;

   // H.264 header types.
   localparam logic [4:0] H264_MAX_KNOWN = 5'd9;
   localparam logic [4:0] H264_SLICE_P   = 5'd1;
   localparam logic [4:0] H264_SLICE_IDR = 5'd5;

   // H.265 header types.
   localparam logic [5:0] H265_TRAIL_R = 6'd1;
   localparam logic [5:0] H265_IDR     = 6'd19;
   localparam logic [5:0] H265_VPS     = 6'd32;
   localparam logic [5:0] H265_SPS     = 6'd33;
   localparam logic [5:0] H265_PPS     = 6'd34;
   localparam logic [5:0] H265_SEI     = 6'd39;

   typedef enum logic {
      CODEC_H264 = 1'b0,
      CODEC_H265 = 1'b1
   } codec_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_TYPE = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   // One input byte of a packet.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   // One result record.
   typedef struct packed {
      logic                nal_valid;
      logic [TYPE_W-1:0]   nal_type;
      logic [OFFSET_W-1:0] nal_offset;
      logic [LENGTH_W-1:0] nal_length;
      logic [INDEX_W-1:0]  nal_index;
      logic                packet_done;
      status_type          status;
   } rsp_type;

endpackage

// ===== src/annexb_nal_unit_splitter.sv =====
// ----------------------------------------------------------------------------
// Annex B NAL unit splitter
// Scans packet bytes for start codes and emits one record per NAL unit.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  req_      in         req_valid/req_stall  req_type: data_byte, last_byte
//  rsp_      out        rsp_valid/rsp_stall  rsp_type: NAL record and status
//  csr_      in         csr_valid/csr_ready  codec_mode (1 bit)
//
// One byte is taken per cycle while req_stall is low. A byte yields zero, one
// or two records; they are written into a three-entry result queue as the
// byte is taken and leave it one per cycle while rsp_stall is low. A byte is
// refused while two or more records wait in the queue, so a byte that yields
// two records holds back the next byte until a record leaves the queue.
// Reset is synchronous and clears the scan state, the queue and codec_mode.
module annexb_nal_unit_splitter
   import nalsplit_pkg::*;
(
   input  logic    clock,
   input  logic    reset,

   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,

   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,

   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   // Configuration and scan state.
   codec_type            codec_mode_ff, codec_mode_in;
   logic [23:0]          recent_ff, recent_in;
   logic [POS_W-1:0]     byte_position_ff, byte_position_in;
   logic                 nal_open_ff, nal_open_in;
   logic [TYPE_W-1:0]    open_type_ff, open_type_in;
   logic [OFFSET_W-1:0]  open_start_ff, open_start_in;
   logic [COUNT_W-1:0]   record_count_ff, record_count_in;
   logic                 scan_stopped_ff, scan_stopped_in;
   status_type           error_ff, error_in;
   logic                 fourth_zero_ff, fourth_zero_in;

   // Result queue.
   rsp_type              queue_ff [3];
   rsp_type              queue_in [3];
   logic [1:0]           count_ff, count_in;

   // Step logic.
   logic                 accept;
   logic                 active;
   logic                 hdr_hit;
   logic [POS_W-1:0]     code_start;
   logic [POS_W-1:0]     start_ext;
   logic [LENGTH_W-1:0]  head_length;
   logic [TYPE_W-1:0]    hdr_type;
   logic                 hdr_known;
   logic                 hdr_slice;
   logic                 open_after;
   logic [COUNT_W-1:0]   count_after;
   logic [TYPE_W-1:0]    type_after;
   logic [OFFSET_W-1:0]  start_after;
   status_type           error_after;
   logic                 stopped_after;
   logic [POS_W-1:0]     position_after;
   logic [POS_W-1:0]     end_start_ext;
   logic [LENGTH_W-1:0]  end_length;
   rsp_type              head_result;
   rsp_type              end_result;
   rsp_type              new_first;
   rsp_type              new_second;
   logic [1:0]           new_count;
   logic                 pop;
   logic [1:0]           base;
   rsp_type              shifted0;
   rsp_type              shifted1;

   // Handshakes.
   assign accept    = req_valid && !req_stall;
   assign req_stall = (count_ff >= 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = queue_ff[0];
   assign csr_ready = 1'b1;

   // Configuration write.
   always_comb begin
      codec_mode_in = codec_mode_ff;
      if (csr_valid && csr_ready) begin
         codec_mode_in = codec_type'(csr_data);
      end
   end

   // Start-code detection and the record closed by a new header.
   assign active      = (byte_position_ff < POS_W'(MAX_PACKET_BYTES));
   assign hdr_hit     = active && !scan_stopped_ff && (byte_position_ff >= POS_W'(3))
                        && (recent_ff == START_CODE);
   assign code_start  = byte_position_ff - POS_W'(3) - POS_W'(fourth_zero_ff);
   assign start_ext   = POS_W'(open_start_ff);
   assign head_length = (code_start >= start_ext) ? LENGTH_W'(code_start - start_ext)
                                                  : '0;

   // The closed record ends the packet when it comes on the final byte and
   // the header opens no new NAL.
   always_comb begin
      head_result             = '0;
      head_result.nal_valid   = 1'b1;
      head_result.nal_type    = open_type_ff;
      head_result.nal_offset  = open_start_ff;
      head_result.nal_length  = head_length;
      head_result.nal_index   = INDEX_W'(record_count_ff - COUNT_W'(1));
      head_result.packet_done = req_data.last_byte && !open_after;
      head_result.status      = error_ff;
   end

   // Header type decode for the selected codec.
   always_comb begin
      hdr_type  = '0;
      hdr_known = 1'b0;
      hdr_slice = 1'b0;
      case (codec_mode_ff)
         CODEC_H264: begin
            hdr_type  = TYPE_W'(req_data.data_byte[4:0]);
            hdr_known = (req_data.data_byte[4:0] <= H264_MAX_KNOWN);
            hdr_slice = (req_data.data_byte[4:0] == H264_SLICE_P)
                        || (req_data.data_byte[4:0] == H264_SLICE_IDR);
         end
         CODEC_H265: begin
            hdr_type  = req_data.data_byte[6:1];
            hdr_slice = (hdr_type == H265_TRAIL_R) || (hdr_type == H265_IDR);
            hdr_known = hdr_slice || (hdr_type == H265_VPS) || (hdr_type == H265_SPS)
                        || (hdr_type == H265_PPS) || (hdr_type == H265_SEI);
         end
         default: begin
            hdr_type  = '0;
            hdr_known = 1'b0;
            hdr_slice = 1'b0;
         end
      endcase
   end

   // State after the header byte has been handled.
   always_comb begin
      open_after    = nal_open_ff;
      count_after   = record_count_ff;
      type_after    = open_type_ff;
      start_after   = open_start_ff;
      error_after   = error_ff;
      stopped_after = scan_stopped_ff;
      if (hdr_hit) begin
         open_after = 1'b0;
         if (!hdr_known) begin
            if (codec_mode_ff == CODEC_H265) begin
               error_after   = STATUS_BAD_TYPE;
               stopped_after = 1'b1;
            end
         end else if (record_count_ff >= COUNT_W'(MAX_NALS)) begin
            error_after   = STATUS_OVERFLOW;
            stopped_after = 1'b1;
         end else begin
            count_after   = record_count_ff + COUNT_W'(1);
            open_after    = 1'b1;
            type_after    = hdr_type;
            start_after   = OFFSET_W'(byte_position_ff);
            stopped_after = scan_stopped_ff || hdr_slice;
         end
      end
   end

   // Final record of the packet: the open NAL, or an empty record.
   assign position_after = active ? (byte_position_ff + POS_W'(1)) : byte_position_ff;
   assign end_start_ext  = POS_W'(start_after);
   assign end_length     = (position_after >= end_start_ext)
                           ? LENGTH_W'(position_after - end_start_ext) : '0;

   always_comb begin
      end_result             = '0;
      end_result.packet_done = 1'b1;
      end_result.status      = error_after;
      if (open_after) begin
         end_result.nal_valid  = 1'b1;
         end_result.nal_type   = type_after;
         end_result.nal_offset = start_after;
         end_result.nal_length = end_length;
         end_result.nal_index  = INDEX_W'(count_after - COUNT_W'(1));
      end
   end

   // Records made by this byte, in order. The final byte adds its own record
   // only when a NAL is still open or no record was closed by a header.
   always_comb begin
      new_first  = hdr_hit && nal_open_ff ? head_result : end_result;
      new_second = end_result;
      new_count  = 2'd0;
      if (accept) begin
         new_count = 2'(hdr_hit && nal_open_ff)
                     + 2'(req_data.last_byte && (open_after || !(hdr_hit && nal_open_ff)));
      end
   end

   // Scan state update.
   always_comb begin
      recent_in        = recent_ff;
      byte_position_in = byte_position_ff;
      nal_open_in      = nal_open_ff;
      open_type_in     = open_type_ff;
      open_start_in    = open_start_ff;
      record_count_in  = record_count_ff;
      scan_stopped_in  = scan_stopped_ff;
      error_in         = error_ff;
      fourth_zero_in   = fourth_zero_ff;
      if (accept) begin
         if (req_data.last_byte) begin
            recent_in        = '0;
            byte_position_in = '0;
            nal_open_in      = 1'b0;
            open_type_in     = '0;
            open_start_in    = '0;
            record_count_in  = '0;
            scan_stopped_in  = 1'b0;
            error_in         = STATUS_OK;
            fourth_zero_in   = 1'b0;
         end else begin
            nal_open_in      = open_after;
            open_type_in     = type_after;
            open_start_in    = start_after;
            record_count_in  = count_after;
            scan_stopped_in  = stopped_after;
            error_in         = error_after;
            byte_position_in = position_after;
            if (active) begin
               fourth_zero_in = (byte_position_ff >= POS_W'(3))
                                && (recent_ff[23:16] == 8'h00);
               recent_in      = {recent_ff[15:0], req_data.data_byte};
            end
         end
      end
   end

   // Result queue: drop the head on a transfer, then append new records.
   assign pop      = rsp_valid && !rsp_stall;
   assign base     = count_ff - 2'(pop);
   assign shifted0 = pop ? queue_ff[1] : queue_ff[0];
   assign shifted1 = pop ? queue_ff[2] : queue_ff[1];

   always_comb begin
      queue_in[0] = (base >= 2'd1) ? shifted0 : new_first;
      queue_in[1] = (base >= 2'd2) ? shifted1
                  : ((base == 2'd1) ? new_first : new_second);
      queue_in[2] = (base == 2'd3) ? queue_ff[2]
                  : ((base == 2'd2) ? new_first
                  : ((base == 2'd1) ? new_second : queue_ff[2]));
      count_in    = base + new_count;
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         codec_mode_ff    <= CODEC_H264;
         recent_ff        <= '0;
         byte_position_ff <= '0;
         nal_open_ff      <= 1'b0;
         open_type_ff     <= '0;
         open_start_ff    <= '0;
         record_count_ff  <= '0;
         scan_stopped_ff  <= 1'b0;
         error_ff         <= STATUS_OK;
         fourth_zero_ff   <= 1'b0;
         count_ff         <= '0;
      end else begin
         codec_mode_ff    <= codec_mode_in;
         recent_ff        <= recent_in;
         byte_position_ff <= byte_position_in;
         nal_open_ff      <= nal_open_in;
         open_type_ff     <= open_type_in;
         open_start_ff    <= open_start_in;
         record_count_ff  <= record_count_in;
         scan_stopped_ff  <= scan_stopped_in;
         error_ff         <= error_in;
         fourth_zero_ff   <= fourth_zero_in;
         count_ff         <= count_in;
      end
   end

   // Queue payload needs no reset.
   always_ff @(posedge clock) begin
      queue_ff[0] <= queue_in[0];
      queue_ff[1] <= queue_in[1];
      queue_ff[2] <= queue_in[2];
   end

   // Checks.
   a_packet_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.last_byte) |=> (byte_position_ff == '0) && (record_count_ff == '0)
                                          && !nal_open_ff)
      else $error("scan state not cleared after the final byte");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      record_count_ff <= COUNT_W'(MAX_NALS))
      else $error("record count above table limit");

   a_error_stops: assert property (@(posedge clock) disable iff (reset)
      (error_ff != STATUS_OK) |-> scan_stopped_ff)
      else $error("error status without a stopped scan");

   a_open_counted: assert property (@(posedge clock) disable iff (reset)
      nal_open_ff |-> (record_count_ff != '0))
      else $error("open NAL without a table entry");

endmodule
